@@ hw/rtl/stack_bytecode_execute_unit_macros.svh @@
// ----------------------------------------------------------------------------
// stack bytecode execute unit assertion macros
// clocked property checks, switched off as a group with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_EXECUTE_UNIT_MACROS_SVH
`define STACK_BYTECODE_EXECUTE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// check outside reset
`define SBEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check on every edge, reset included
`define SBEU_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define SBEU_ASSERT(lbl, prop, msg)
`define SBEU_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/sbeu_pkg.sv @@
// ----------------------------------------------------------------------------
// sbeu_pkg
// sizes, opcodes, tags and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbeu_pkg;

    // storage sizes
    localparam int STACK_DEPTH  = 32;
    localparam int GLOBAL_SLOTS = 64;
    localparam int ARRAY_SLOTS  = 16;
    localparam int ARRAY_LENGTH = 256;

    // derived widths
    localparam int STK_AW    = $clog2(STACK_DEPTH);
    localparam int LVL_W     = $clog2(STACK_DEPTH + 1);
    localparam int GLB_AW    = $clog2(GLOBAL_SLOTS);
    localparam int ARR_SW    = (ARRAY_SLOTS > 1) ? $clog2(ARRAY_SLOTS) : 1;
    localparam int ARR_IW    = $clog2(ARRAY_LENGTH);
    localparam int ARR_AW    = ARR_SW + ARR_IW;
    localparam int ARR_DEPTH = ARRAY_SLOTS * ARRAY_LENGTH;
    localparam int SIZE_W    = $clog2(ARRAY_LENGTH + 1);

    // constants
    localparam logic [31:0] RNG_MUL      = 32'd1664525;
    localparam logic [31:0] RNG_ADD      = 32'd1013904223;
    localparam logic [31:0] RNG_INIT     = 32'd12345;
    localparam logic [31:0] EMPTY_RESULT = 32'd128;
    localparam logic [15:0] NO_ENTRY     = 16'hFFFF;
    localparam logic [31:0] SHIFT_MASK   = 32'd31;
    localparam logic [3:0]  MAX_ARGS     = 4'd8;

    typedef enum logic [1:0] {
        TAG_INT  = 2'd0,
        TAG_LIT  = 2'd1,
        TAG_ARR  = 2'd2,
        TAG_NONE = 2'd3
    } tag_t;

    typedef enum logic [5:0] {
        K_BEGIN = 6'd0,  K_SETG  = 6'd1,  K_DEFA  = 6'd2,  K_PUSHI = 6'd3,
        K_PUSHL = 6'd4,  K_PUSHA = 6'd5,  K_LOAD  = 6'd6,  K_STORE = 6'd7,
        K_ADD   = 6'd8,  K_SUB   = 6'd9,  K_MUL   = 6'd10, K_DIV   = 6'd11,
        K_MOD   = 6'd12, K_NEG   = 6'd13, K_AND   = 6'd14, K_OR    = 6'd15,
        K_XOR   = 6'd16, K_SHL   = 6'd17, K_SHR   = 6'd18, K_EQ    = 6'd19,
        K_NE    = 6'd20, K_LT    = 6'd21, K_LE    = 6'd22, K_GT    = 6'd23,
        K_GE    = 6'd24, K_NOT   = 6'd25, K_POP   = 6'd26, K_DUP   = 6'd27,
        K_JMP   = 6'd28, K_JT    = 6'd29, K_JF    = 6'd30, K_PJT   = 6'd31,
        K_PJF   = 6'd32, K_RET   = 6'd33, K_AGET  = 6'd34, K_ASET  = 6'd35,
        K_ALEN  = 6'd36, K_CALL  = 6'd37
    } kind_t;

    typedef enum logic [2:0] {
        B_ABS    = 3'd0,
        B_MIN    = 3'd1,
        B_MAX    = 3'd2,
        B_CLAMP  = 3'd3,
        B_SEED   = 3'd4,
        B_RANDOM = 3'd5,
        B_VOID   = 3'd6
    } builtin_t;

    typedef enum logic {
        CFG_CODE_LENGTH = 1'b0,
        CFG_ARRAY_COUNT = 1'b1
    } cfg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_en;
        logic stk_rd;
        logic stk_pop;
        logic pop_cap;
        logic mem_rd;
        logic mul_en;
        logic rng_upd;
        logic div_start;
        logic exec;
        logic out_load;
    } sbeu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic pop_pending;
        logic is_mem;
        logic use_mul;
        logic rng_go;
        logic is_div;
        logic div_done;
        logic out_free;
    } sbeu_status_t;

endpackage

@@ hw/rtl/sbeu_div.sv @@
// ----------------------------------------------------------------------------
// sbeu_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbeu_div import sbeu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    // trial subtract of the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd32;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[32]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hw/rtl/sbeu_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbeu_ctrl
// sequencer: clear pass, operand pops, memory/multiply/divide steps, result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_bytecode_execute_unit_macros.svh"

module sbeu_ctrl import sbeu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  sbeu_status_t st,
    output sbeu_cmd_t    cmd
);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_FETCH   = 14'b00000000000100,
        S_POPRD   = 14'b00000000001000,
        S_POPCAP  = 14'b00000000010000,
        S_ROUTE   = 14'b00000000100000,
        S_MEMRD   = 14'b00000001000000,
        S_MULT    = 14'b00000010000000,
        S_RNGADD  = 14'b00000100000000,
        S_DIVGO   = 14'b00001000000000,
        S_DIVWAIT = 14'b00010000000000,
        S_EXEC    = 14'b00100000000000,
        S_TOPRD   = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (st.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = st.pop_pending ? S_POPRD : S_ROUTE;
            end
            S_POPRD: begin
                cmd.stk_rd  = 1'b1;
                cmd.stk_pop = 1'b1;
                state_next  = S_POPCAP;
            end
            S_POPCAP: begin
                cmd.pop_cap = 1'b1;
                state_next  = S_FETCH;
            end
            S_ROUTE: begin
                if (st.is_mem)       state_next = S_MEMRD;
                else if (st.use_mul) state_next = S_MULT;
                else if (st.is_div)  state_next = S_DIVGO;
                else                 state_next = S_EXEC;
            end
            S_MEMRD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_EXEC;
            end
            S_MULT: begin
                cmd.mul_en = 1'b1;
                state_next = st.rng_go ? S_RNGADD : S_EXEC;
            end
            S_RNGADD: begin
                cmd.rng_upd = 1'b1;
                state_next  = S_DIVWAIT;
            end
            S_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (st.div_done) state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_TOPRD;
            end
            S_TOPRD: begin
                cmd.stk_rd = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    `SBEU_ASSERT(a_out_free, cmd.out_load |-> st.out_free, "result loaded over a waiting beat")
    `SBEU_ASSERT(a_one_item, (s_valid && s_ready) |=> !s_ready, "beat accepted while busy")
    `SBEU_ASSERT(a_div_hold, (state_reg == S_DIVWAIT && !st.div_done) |=> state_reg == S_DIVWAIT, "left divide wait early")
    `SBEU_ASSERT_ANY(a_rst_block, !aresetn |=> !s_ready, "input open right after reset")

endmodule

@@ hw/rtl/sbeu_dp.sv @@
// ----------------------------------------------------------------------------
// sbeu_dp
// datapath: stack, globals, array pool, alu, multiplier, divider, result reg
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_bytecode_execute_unit_macros.svh"

module sbeu_dp import sbeu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  sbeu_cmd_t          cmd,
    output sbeu_status_t       st,
    input  logic [5:0]         s_kind,
    input  logic signed [31:0] s_immediate,
    input  logic [7:0]         s_slot,
    input  logic [2:0]         s_builtin,
    input  logic [3:0]         s_arg_count,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_next_ip,
    output logic               m_halted,
    output logic signed [31:0] m_return_value,
    output logic [1:0]         m_return_tag
);

    function automatic logic [31:0] mag(input logic [31:0] v);
        mag = v[31] ? (32'd0 - v) : v;
    endfunction

    // item fields
    logic [5:0]  kind_reg;
    logic [31:0] imm_reg;
    logic [7:0]  slot_reg;
    logic [2:0]  bid_reg;

    // config and architectural state
    logic [14:0]      code_len_reg;
    logic [4:0]       arr_cnt_reg;
    logic [15:0]      ip_reg;
    logic [15:0]      ip_next;
    logic [LVL_W-1:0] level_reg;
    logic [31:0]      rs_reg;
    logic             halt_reg;

    // operand gathering
    logic [31:0] args_reg [8];
    logic [1:0]  tag0_reg;
    logic [3:0]  pops_left_reg;
    logic        peek_reg;
    logic [3:0]  npop;
    logic        npeek;

    // memories and read registers
    logic [33:0]       smem [STACK_DEPTH];
    logic [33:0]       gmem [GLOBAL_SLOTS];
    logic [31:0]       amem [ARR_DEPTH];
    logic [SIZE_W-1:0] sizes [ARRAY_SLOTS];
    logic [GLOBAL_SLOTS-1:0] gvalid_reg;
    logic [33:0] stk_rd_reg;
    logic        empty_reg;
    logic [33:0] g_rd_reg;
    logic        g_rd_ok_reg;
    logic [31:0] a_rd_reg;
    logic [ARR_AW:0] clr_cnt_reg;
    logic        clr_done;

    // arithmetic
    logic [31:0] mul_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_lo;
    logic [31:0] rng_new;
    logic        div_busy;
    logic [31:0] div_q;
    logic [31:0] div_r;
    logic [31:0] div_dvd;
    logic [31:0] div_dvs;

    // execute step
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [4:0]  shamt;
    logic [31:0] alu_val;
    logic [15:0] off;
    logic [15:0] br_ip;
    logic [15:0] br_tgt;
    logic        glb_ok;
    logic        arr_ok;
    logic        a_ok;
    logic [SIZE_W-1:0] sz_rd;
    logic [SIZE_W-1:0] sz_new;
    logic [ARR_AW-1:0] a_addr;
    logic        rng_go;
    logic        push_en;
    logic [1:0]  push_tag;
    logic [31:0] push_val;
    logic        halt_next;
    logic        g_we;
    logic [33:0] g_wdata;
    logic        a_we;
    logic        sz_we;
    logic        seed_we;
    logic        begin_en;
    logic [2:0]  cap_idx;
    logic [STK_AW-1:0] top_idx;
    logic        m_valid_reg;

    assign op_a    = args_reg[0];
    assign op_b    = args_reg[1];
    assign shamt   = 5'(op_b & SHIFT_MASK);
    assign off     = imm_reg[15:0];
    assign br_ip   = ip_reg + 16'd3;
    assign br_tgt  = br_ip + off;
    assign glb_ok  = {1'b0, slot_reg} < 9'(GLOBAL_SLOTS);
    assign arr_ok  = ({3'b000, arr_cnt_reg} > slot_reg) && ({1'b0, slot_reg} < 9'(ARRAY_SLOTS));
    assign sz_rd   = sizes[slot_reg[ARR_SW-1:0]];
    assign a_ok    = arr_ok && (op_a < 32'(sz_rd)) && (op_a < 32'(ARRAY_LENGTH));
    assign a_addr  = {slot_reg[ARR_SW-1:0], op_a[ARR_IW-1:0]};
    assign sz_new  = (off > 16'(ARRAY_LENGTH)) ? SIZE_W'(ARRAY_LENGTH) : off[SIZE_W-1:0];
    assign rng_go  = (kind_reg == K_CALL) && (bid_reg == B_RANDOM) && !op_a[31] && (op_a != 32'd0);
    assign cap_idx = 3'(pops_left_reg - 4'd1);
    assign top_idx = STK_AW'(level_reg - 1'b1);
    assign clr_done = (clr_cnt_reg == (ARR_AW + 1)'(ARR_DEPTH));

    // pops needed by the incoming beat
    always_comb begin
        npop  = 4'd0;
        npeek = 1'b0;
        case (s_kind) inside
            K_NEG, K_NOT, K_POP, K_JT, K_JF, K_STORE, K_AGET: npop = 4'd1;
            [K_ADD:K_GE], K_ASET:                             npop = 4'd2;
            K_DUP, K_PJT, K_PJF: begin
                npop  = 4'd1;
                npeek = 1'b1;
            end
            K_CALL: npop = (s_arg_count > MAX_ARGS) ? MAX_ARGS : s_arg_count;
            default: npop = 4'd0;
        endcase
    end

    // status to the sequencer
    always_comb begin
        st.clr_done    = clr_done;
        st.pop_pending = (pops_left_reg != 4'd0);
        st.is_mem      = (kind_reg == K_LOAD) || (kind_reg == K_AGET);
        st.use_mul     = (kind_reg == K_MUL) || rng_go;
        st.rng_go      = rng_go;
        st.is_div      = (kind_reg == K_DIV) || (kind_reg == K_MOD);
        st.div_done    = !div_busy;
        st.out_free    = !m_valid_reg || m_ready;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_len_reg <= '0;
            arr_cnt_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CODE_LENGTH: code_len_reg <= cfg_data;
                CFG_ARRAY_COUNT: arr_cnt_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= s_kind;
            imm_reg  <= 32'(s_immediate);
            slot_reg <= s_slot;
            bid_reg  <= s_builtin;
        end
    end

    // operand gathering control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pops_left_reg <= '0;
            peek_reg      <= 1'b0;
        end else if (cmd.accept) begin
            pops_left_reg <= npop;
            peek_reg      <= npeek;
        end else if (cmd.pop_cap) begin
            pops_left_reg <= pops_left_reg - 4'd1;
        end
    end

    // operand registers, missing operands read as integer zero
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            for (int i = 0; i < 8; i++) begin
                args_reg[i] <= '0;
            end
            tag0_reg <= TAG_INT;
        end else if (cmd.pop_cap) begin
            args_reg[cap_idx] <= empty_reg ? 32'd0 : stk_rd_reg[31:0];
            if (cap_idx == 3'd0) begin
                tag0_reg <= empty_reg ? TAG_INT : stk_rd_reg[33:32];
            end
        end
    end

    // alu for the binary and unary ops
    always_comb begin
        case (kind_reg)
            K_ADD: alu_val = op_a + op_b;
            K_SUB: alu_val = op_a - op_b;
            K_MUL: alu_val = mul_reg;
            K_DIV: alu_val = (op_b == 32'd0) ? 32'd0
                           : ((op_a[31] ^ op_b[31]) ? (32'd0 - div_q) : div_q);
            K_MOD: alu_val = (op_b == 32'd0) ? 32'd0
                           : (op_a[31] ? (32'd0 - div_r) : div_r);
            K_NEG: alu_val = 32'd0 - op_a;
            K_AND: alu_val = op_a & op_b;
            K_OR:  alu_val = op_a | op_b;
            K_XOR: alu_val = op_a ^ op_b;
            K_SHL: alu_val = op_a << shamt;
            K_SHR: alu_val = 32'($signed(op_a) >>> shamt);
            K_EQ:  alu_val = {31'd0, op_a == op_b};
            K_NE:  alu_val = {31'd0, op_a != op_b};
            K_LT:  alu_val = {31'd0, $signed(op_a) < $signed(op_b)};
            K_LE:  alu_val = {31'd0, !($signed(op_b) < $signed(op_a))};
            K_GT:  alu_val = {31'd0, $signed(op_b) < $signed(op_a)};
            K_GE:  alu_val = {31'd0, !($signed(op_a) < $signed(op_b))};
            K_NOT: alu_val = {31'd0, op_a == 32'd0};
            default: alu_val = 32'd0;
        endcase
    end

    // execute step decode
    always_comb begin
        push_en   = 1'b0;
        push_tag  = TAG_INT;
        push_val  = 32'd0;
        ip_next   = ip_reg + 16'd1;
        halt_next = 1'b0;
        g_we      = 1'b0;
        g_wdata   = {TAG_INT, imm_reg};
        a_we      = 1'b0;
        sz_we     = 1'b0;
        seed_we   = 1'b0;
        begin_en  = 1'b0;
        case (kind_reg) inside
            K_BEGIN: begin
                begin_en  = 1'b1;
                ip_next   = off;
                halt_next = (off == NO_ENTRY);
            end
            K_SETG: begin
                ip_next = ip_reg;
                g_we    = glb_ok;
            end
            K_DEFA: begin
                ip_next = ip_reg;
                sz_we   = ({1'b0, slot_reg} < 9'(ARRAY_SLOTS));
            end
            K_PUSHI: begin
                push_en  = 1'b1;
                push_val = imm_reg;
                ip_next  = ip_reg + 16'd5;
            end
            K_PUSHL, K_PUSHA: begin
                push_en  = 1'b1;
                push_tag = (kind_reg == K_PUSHL) ? TAG_LIT : TAG_ARR;
                push_val = {24'd0, slot_reg};
                ip_next  = ip_reg + 16'd2;
            end
            K_LOAD: begin
                push_en  = 1'b1;
                push_tag = g_rd_ok_reg ? g_rd_reg[33:32] : TAG_INT;
                push_val = g_rd_ok_reg ? g_rd_reg[31:0] : 32'd0;
                ip_next  = ip_reg + 16'd2;
            end
            K_STORE: begin
                g_we    = glb_ok;
                g_wdata = {tag0_reg, op_a};
                ip_next = ip_reg + 16'd2;
            end
            [K_ADD:K_NOT]: begin
                push_en  = 1'b1;
                push_val = alu_val;
            end
            K_DUP: begin
                push_en  = 1'b1;
                push_tag = tag0_reg;
                push_val = op_a;
            end
            K_JMP: ip_next = br_tgt;
            K_JT, K_PJT: ip_next = (op_a != 32'd0) ? br_tgt : br_ip;
            K_JF, K_PJF: ip_next = (op_a == 32'd0) ? br_tgt : br_ip;
            K_RET: halt_next = 1'b1;
            K_AGET: begin
                push_en  = 1'b1;
                push_val = a_ok ? a_rd_reg : 32'd0;
                ip_next  = ip_reg + 16'd2;
            end
            K_ASET: begin
                a_we    = a_ok;
                ip_next = ip_reg + 16'd2;
            end
            K_ALEN: begin
                push_en  = 1'b1;
                push_val = arr_ok ? 32'(sz_rd) : 32'd0;
                ip_next  = ip_reg + 16'd2;
            end
            K_CALL: begin
                ip_next = ip_reg + 16'd3;
                case (bid_reg)
                    B_ABS: begin
                        push_en  = 1'b1;
                        push_val = mag(op_a);
                    end
                    B_MIN: begin
                        push_en  = 1'b1;
                        push_val = ($signed(op_a) < $signed(op_b)) ? op_a : op_b;
                    end
                    B_MAX: begin
                        push_en  = 1'b1;
                        push_val = ($signed(op_b) < $signed(op_a)) ? op_a : op_b;
                    end
                    B_CLAMP: begin
                        push_en  = 1'b1;
                        push_val = ($signed(op_a) < $signed(op_b)) ? op_b
                                 : (($signed(args_reg[2]) < $signed(op_a)) ? args_reg[2] : op_a);
                    end
                    B_SEED: seed_we = 1'b1;
                    B_RANDOM: begin
                        push_en  = 1'b1;
                        push_val = rng_go ? div_r : 32'd0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // instruction pointer, level, halt and random state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_reg    <= '0;
            level_reg <= '0;
            halt_reg  <= 1'b0;
            rs_reg    <= RNG_INIT;
        end else begin
            if (cmd.stk_rd && cmd.stk_pop && !peek_reg && level_reg != '0) begin
                level_reg <= level_reg - 1'b1;
            end
            if (cmd.rng_upd) begin
                rs_reg <= rng_new;
            end
            if (cmd.exec) begin
                ip_reg   <= ip_next;
                halt_reg <= halt_next;
                if (seed_we) begin
                    rs_reg <= op_a;
                end
                if (begin_en) begin
                    level_reg <= '0;
                end else if (push_en && level_reg < LVL_W'(STACK_DEPTH)) begin
                    level_reg <= level_reg + 1'b1;
                end
            end
        end
    end

    // value stack, written by push, read at the top
    always_ff @(posedge aclk) begin
        if (cmd.exec && push_en && !begin_en && level_reg < LVL_W'(STACK_DEPTH)) begin
            smem[level_reg[STK_AW-1:0]] <= {push_tag, push_val};
        end
        if (cmd.stk_rd) begin
            stk_rd_reg <= smem[top_idx];
            empty_reg  <= (level_reg == '0);
        end
    end

    // global table
    always_ff @(posedge aclk) begin
        if (cmd.exec && g_we) begin
            gmem[slot_reg[GLB_AW-1:0]] <= g_wdata;
        end
        if (cmd.mem_rd) begin
            g_rd_reg    <= gmem[slot_reg[GLB_AW-1:0]];
            g_rd_ok_reg <= glb_ok && gvalid_reg[slot_reg[GLB_AW-1:0]];
        end
    end

    // global valid bits, an unwritten slot reads integer zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gvalid_reg <= '0;
        end else if (cmd.exec && g_we) begin
            gvalid_reg[slot_reg[GLB_AW-1:0]] <= 1'b1;
        end
    end

    // array pool with the clearing sweep
    always_ff @(posedge aclk) begin
        if (cmd.clr_en && !clr_done) begin
            amem[clr_cnt_reg[ARR_AW-1:0]] <= '0;
        end else if (cmd.exec && a_we) begin
            amem[a_addr] <= op_b;
        end
        if (cmd.mem_rd) begin
            a_rd_reg <= amem[a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en && !clr_done) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // array sizes
    always_ff @(posedge aclk) begin
        if (cmd.exec && sz_we) begin
            sizes[slot_reg[ARR_SW-1:0]] <= sz_new;
        end
    end

    // shared multiplier, registered product
    assign mul_a  = rng_go ? rs_reg : op_a;
    assign mul_b  = rng_go ? RNG_MUL : op_b;
    assign mul_lo = mul_a * mul_b;
    assign rng_new = mul_reg + RNG_ADD;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            mul_reg <= mul_lo;
        end
    end

    // shared divider for divide, modulo and random range
    assign div_dvd = cmd.rng_upd ? {16'd0, rng_new[31:16]} : mag(op_a);
    assign div_dvs = cmd.rng_upd ? op_a : mag(op_b);

    sbeu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rng_upd || cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_next_ip      <= ip_reg;
            m_halted       <= halt_reg || (ip_reg >= {1'b0, code_len_reg});
            m_return_value <= empty_reg ? $signed(EMPTY_RESULT) : $signed(stk_rd_reg[31:0]);
            m_return_tag   <= empty_reg ? TAG_NONE : stk_rd_reg[33:32];
        end
    end

    assign m_valid = m_valid_reg;

    `SBEU_ASSERT(a_level_max, level_reg <= LVL_W'(STACK_DEPTH), "stack level past depth")
    `SBEU_ASSERT(a_push_inc, (cmd.exec && push_en && level_reg < LVL_W'(STACK_DEPTH)) |=> level_reg == $past(level_reg) + 1'b1, "push did not raise level")
    `SBEU_ASSERT(a_clear_first, cmd.accept |-> clr_done, "beat taken before array clear")

endmodule

@@ hw/rtl/stack_bytecode_execute_unit.sv @@
// steps: per input beat, a stack pop per operand (up to 8 on call), then a global or array read,
//   a multiply, a divide/modulo or the random multiply and divide as needed, then execute, result
// flow: one item at a time, a new beat is taken only after the last result is loaded; set by the sequencer
// reset: synchronous active-low aresetn; then a clear of all 4096 array words with s_ready low,
//   configuration writes accepted throughout
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit
// executes one decoded instruction of a tagged-value stack machine per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_bytecode_execute_unit import sbeu_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [5:0]         s_kind,
    input  logic signed [31:0] s_immediate,
    input  logic [7:0]         s_slot,
    input  logic [2:0]         s_builtin,
    input  logic [3:0]         s_arg_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_next_ip,
    output logic               m_halted,
    output logic signed [31:0] m_return_value,
    output logic [1:0]         m_return_tag,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [14:0]        cfg_data
);

    sbeu_cmd_t    cmd;
    sbeu_status_t st;

    // sequencer
    sbeu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // datapath
    sbeu_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .s_kind         (s_kind),
        .s_immediate    (s_immediate),
        .s_slot         (s_slot),
        .s_builtin      (s_builtin),
        .s_arg_count    (s_arg_count),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_ip      (m_next_ip),
        .m_halted       (m_halted),
        .m_return_value (m_return_value),
        .m_return_tag   (m_return_tag)
    );

endmodule
